/* rtl/dpsg_pkg.sv */
// Shared types and constants of the dash pattern segment generator.
`timescale 1ns / 1ps
`default_nettype none
package dpsg_pkg;

    localparam int COORD_W = 24;   // signed fixed-point coordinate
    localparam int THICK_W = 23;   // unsigned fixed-point length
    localparam int WIDE_W  = 26;   // working width for x and y sums
    localparam int COLOR_W = 32;
    localparam int DIV_STEPS = 24; // one remainder bit per cycle over |phase|
    localparam int DIV_CNT_W = 5;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam logic [7:0] DASH_NUM = 8'd166; // 0.65 in 1/256 units

    typedef enum logic [1:0] {
        STYLE_SOLID    = 2'd0,
        STYLE_DOTTED   = 2'd1,
        STYLE_DASHED   = 2'd2,
        STYLE_SQUIGGLE = 2'd3
    } style_t;

    typedef enum logic [2:0] {
        REG_STYLE     = 3'd0,
        REG_THICKNESS = 3'd1,
        REG_PERIOD    = 3'd2,
        REG_AMPLITUDE = 3'd3,
        REG_PHASE     = 3'd4,
        REG_COLOR     = 3'd5,
        REG_SCREEN    = 3'd6,
        REG_NONE      = 3'd7
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_DIV  = 2'd1,
        ST_PREP = 2'd2,
        ST_EMIT = 2'd3
    } state_t;

    typedef struct packed {
        style_t                      style_type;
        logic [THICK_W-1:0]          stroke_thickness;
        logic [THICK_W-1:0]          pattern_period;
        logic [THICK_W-1:0]          wave_amplitude;
        logic signed [COORD_W-1:0]   pattern_phase;
        logic [COLOR_W-1:0]          stroke_color;
        logic                        screen_space;
    } cfg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] span_start;
        logic signed [COORD_W-1:0] span_end;
        logic signed [COORD_W-1:0] line_y;
        logic [THICK_W-1:0]        fallback_thickness;
    } span_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] seg_x0;
        logic signed [COORD_W-1:0] seg_y0;
        logic signed [COORD_W-1:0] seg_x1;
        logic signed [COORD_W-1:0] seg_y1;
        logic [THICK_W-1:0]        seg_thickness;
        logic [COLOR_W-1:0]        seg_color;
        logic                      seg_screen_space;
        logic                      last_segment;
        logic                      truncated;
    } seg_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic prep;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic span_empty;
        logic solid;
        logic last;
    } sts_t;

endpackage
`default_nettype wire

/* rtl/dpsg_ctrl.sv */
// Sequencer: phase remainder steps, pattern setup and segment emission.
`timescale 1ns / 1ps
`default_nettype none
module dpsg_ctrl
    import dpsg_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic span_valid,
    output logic      span_ready,
    output logic      seg_valid,
    input  wire logic seg_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    state_t                 state_reg, state_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                   seg_valid_reg, seg_valid_next;
    logic                   out_free;

    assign out_free = !seg_valid_reg || seg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            seg_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            seg_valid_reg <= seg_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (span_valid && !sts.span_empty)
                    state_next = sts.solid ? ST_EMIT : ST_DIV;
            end
            ST_DIV:
            begin
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                    state_next = ST_PREP;
            end
            ST_PREP:
                state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (out_free && sts.last)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd            = '0;
        span_ready     = 1'b0;
        cnt_next       = cnt_reg;
        seg_valid_next = seg_valid_reg && !seg_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                span_ready   = 1'b1;
                cmd.load     = span_valid;
                cnt_next     = '0;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
            end
            ST_PREP:
                cmd.prep     = 1'b1;
            ST_EMIT:
            begin
                cmd.emit     = out_free;
                if (out_free)
                    seg_valid_next = 1'b1;
            end
            default:
                cmd = '0;
        endcase
    end

    assign seg_valid = seg_valid_reg;

`ifndef SYNTH
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!seg_valid_reg || seg_ready))
        else $error("pending segment overwritten");
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && sts.last) |=> (state_reg == ST_IDLE))
        else $error("sequencer did not return to idle after last segment");
    a_pattern_divides: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && !sts.span_empty && !sts.solid) |=> (state_reg == ST_DIV && cnt_reg == '0))
        else $error("patterned span skipped the remainder steps");
`endif

endmodule
`default_nettype wire

/* rtl/dpsg_datapath.sv */
// Datapath: span capture, phase remainder, pattern stepping and result register.
`timescale 1ns / 1ps
`default_nettype none
module dpsg_datapath
    import dpsg_pkg::*;
#(
    parameter int MAX_SEGMENTS = 64,
    parameter int FRAC_BITS    = 8
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire span_t span,
    input  wire cmd_t  cmd,
    output sts_t       sts,
    output seg_t       seg
);

    localparam int NW = $clog2(MAX_SEGMENTS + 1);
    localparam logic [THICK_W-1:0] ONE_FX    = THICK_W'(1 << FRAC_BITS);
    localparam logic [THICK_W-1:0] PER_DOT   = THICK_W'(3 << FRAC_BITS);
    localparam logic [THICK_W-1:0] PER_DASH  = THICK_W'(7 << FRAC_BITS);
    localparam logic [THICK_W-1:0] PER_SQUIG = THICK_W'(4 << FRAC_BITS);
    localparam logic [THICK_W-1:0] AMP_DEF   = THICK_W'((3 << FRAC_BITS) / 2);
    localparam logic signed [WIDE_W-1:0] SAT_MAX = WIDE_W'(8388607);
    localparam logic signed [WIDE_W-1:0] SAT_MIN = -WIDE_W'(8388608);

    function automatic logic signed [COORD_W-1:0] sat24(input logic signed [WIDE_W-1:0] v);
        logic signed [COORD_W-1:0] r;
        if (v > SAT_MAX)
            r = SAT_MAX[COORD_W-1:0];
        else if (v < SAT_MIN)
            r = SAT_MIN[COORD_W-1:0];
        else
            r = v[COORD_W-1:0];
        return r;
    endfunction

    logic signed [COORD_W-1:0] x0_reg, x1_reg, y_reg;
    logic [THICK_W-1:0]        th_reg, period_reg, amp_reg, rem_reg, len_reg;
    logic [COORD_W-1:0]        dvd_reg;
    logic signed [WIDE_W-1:0]  x_reg;
    logic [NW-1:0]             n_reg;
    logic                      up_reg;
    seg_t                      seg_reg, seg_next;

    logic                      solid, squig;
    logic [COORD_W-1:0]        ph_abs;
    logic [THICK_W-1:0]        period_sel;
    logic [THICK_W:0]          trial, trial_sub;
    logic [THICK_W+7:0]        dash_prod;
    logic signed [WIDE_W-1:0]  x_cur, x1_w, y_w, nx_raw, nx, x_adv, y_lo, y_hi;
    logic signed [WIDE_W-1:0]  y0_w, y1_w;
    logic [NW:0]               n_inc;
    logic                      more, last, adv_inside;

    assign solid = (cfg.style_type == STYLE_SOLID);
    assign squig = (cfg.style_type == STYLE_SQUIGGLE);
    assign ph_abs = cfg.pattern_phase[COORD_W-1] ? (~cfg.pattern_phase + 1'b1)
                                                 : cfg.pattern_phase;

    always_comb
    begin
        if (cfg.pattern_period > ONE_FX)
            period_sel = cfg.pattern_period;
        else
        begin
            unique case (cfg.style_type)
                STYLE_DOTTED: period_sel = PER_DOT;
                STYLE_DASHED: period_sel = PER_DASH;
                default:      period_sel = PER_SQUIG;
            endcase
        end
    end

    // restoring remainder step
    assign trial     = {rem_reg, dvd_reg[COORD_W-1]};
    assign trial_sub = trial - {1'b0, period_reg};
    assign dash_prod = period_reg * DASH_NUM;

    // segment step
    assign x1_w       = WIDE_W'(x1_reg);
    assign y_w        = WIDE_W'(y_reg);
    assign x_cur      = solid ? WIDE_W'(x0_reg) : x_reg;
    assign nx_raw     = x_cur + $signed({3'b000, len_reg});
    assign nx         = (solid || nx_raw > x1_w) ? x1_w : nx_raw;
    assign x_adv      = squig ? nx : (x_cur + $signed({3'b000, period_reg}));
    assign n_inc      = {1'b0, n_reg} + 1'b1;
    assign adv_inside = x_adv < x1_w;
    assign more       = adv_inside && (n_inc < (NW+1)'(MAX_SEGMENTS));
    assign last       = solid || !more;
    assign y_lo       = y_w - $signed({3'b000, amp_reg});
    assign y_hi       = y_w + $signed({3'b000, amp_reg});
    assign y0_w       = !squig ? y_w : (up_reg ? y_hi : y_lo);
    assign y1_w       = !squig ? y_w : (up_reg ? y_lo : y_hi);

    always_comb
    begin
        seg_next                  = seg_reg;
        seg_next.seg_x0           = sat24(x_cur);
        seg_next.seg_y0           = sat24(y0_w);
        seg_next.seg_x1           = sat24(nx);
        seg_next.seg_y1           = sat24(y1_w);
        seg_next.seg_thickness    = th_reg;
        seg_next.seg_color        = cfg.stroke_color;
        seg_next.seg_screen_space = cfg.screen_space;
        seg_next.last_segment     = last;
        seg_next.truncated        = !solid && last && adv_inside;
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x0_reg     <= span.span_start;
            x1_reg     <= span.span_end;
            y_reg      <= span.line_y;
            th_reg     <= (cfg.stroke_thickness != '0) ? cfg.stroke_thickness
                                                       : span.fallback_thickness;
            period_reg <= period_sel;
            amp_reg    <= (cfg.wave_amplitude != '0) ? cfg.wave_amplitude : AMP_DEF;
            dvd_reg    <= ph_abs;
            rem_reg    <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= trial_sub[THICK_W] ? trial[THICK_W-1:0] : trial_sub[THICK_W-1:0];
            dvd_reg <= {dvd_reg[COORD_W-2:0], 1'b0};
        end
        if (cmd.prep)
        begin
            x_reg <= WIDE_W'(x0_reg) - $signed({3'b000, rem_reg});
            unique case (cfg.style_type)
                STYLE_DOTTED: len_reg <= th_reg;
                STYLE_DASHED: len_reg <= dash_prod[THICK_W+7:8];
                default:      len_reg <= {1'b0, period_reg[THICK_W-1:1]};
            endcase
        end
        if (cmd.emit)
        begin
            x_reg   <= x_adv;
            seg_reg <= seg_next;
        end
    end

    // count restarts on every span, solid ones included
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg  <= '0;
            up_reg <= 1'b0;
        end
        else if (cmd.prep || cmd.load)
        begin
            n_reg  <= '0;
            up_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            n_reg  <= n_inc[NW-1:0];
            up_reg <= !up_reg;
        end
    end

    assign sts.span_empty = (span.span_end <= span.span_start);
    assign sts.solid      = solid;
    assign sts.last       = last;
    assign seg            = seg_reg;

`ifndef SYNTH
    a_cap: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= NW'(MAX_SEGMENTS))
        else $error("segment count beyond cap");
    a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (!seg_reg.truncated || seg_reg.last_segment))
        else $error("truncated flag on a segment that is not last");
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.prep |-> (rem_reg < period_reg))
        else $error("phase remainder not below period");
`endif

endmodule
`default_nettype wire

/* rtl/dash_pattern_segment_generator_core.sv */
// Top level of the dash pattern segment generator: register file and core.
`timescale 1ns / 1ps
`default_nettype none
// Turns one horizontal span into the line segments of a decoration style:
// solid, dotted, dashed or squiggle. A span is taken on span_valid/span_ready
// and each segment leaves as one transfer on seg_valid/seg_ready through an
// output register, so the next segment is prepared while the previous one
// waits. A patterned span first takes the bit-serial remainder of |phase| by
// the period (one bit per cycle), then pattern setup (start x and length, with
// dash multiply if dashed), then one segment per cycle unless seg_ready stalls;
// solid spans skip them. At most MAX_SEGMENTS segments are sent per span;
// the last carries last_segment, and truncated when the cap cut the pattern
// short. A span with span_end <= span_start gives no transfer. Configuration
// must be written over the APB port only while the block is idle (the block
// does not enforce it); offsets are 4 * register index, pready is tied high.
module dash_pattern_segment_generator_core
    import dpsg_pkg::*;
#(
    parameter int MAX_SEGMENTS = 64,
    parameter int FRAC_BITS    = 8
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    // span input
    input  wire logic              span_valid,
    output logic                   span_ready,
    input  wire span_t             span,
    // segment output
    output logic                   seg_valid,
    input  wire logic              seg_ready,
    output seg_t                   seg
);

    cfg_t     cfg_reg, cfg_next;
    reg_idx_t reg_idx;
    logic     wr_en;
    cmd_t     cmd;
    sts_t     sts;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;

    // register write decode; indexes past the list are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_STYLE:     cfg_next.style_type       = style_t'(pwdata[1:0]);
                REG_THICKNESS: cfg_next.stroke_thickness = pwdata[THICK_W-1:0];
                REG_PERIOD:    cfg_next.pattern_period   = pwdata[THICK_W-1:0];
                REG_AMPLITUDE: cfg_next.wave_amplitude   = pwdata[THICK_W-1:0];
                REG_PHASE:     cfg_next.pattern_phase    = pwdata[COORD_W-1:0];
                REG_COLOR:     cfg_next.stroke_color     = pwdata[COLOR_W-1:0];
                REG_SCREEN:    cfg_next.screen_space     = pwdata[0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    // read back
    always_comb
    begin
        unique case (reg_idx)
            REG_STYLE:     prdata = DATA_W'(cfg_reg.style_type);
            REG_THICKNESS: prdata = DATA_W'(cfg_reg.stroke_thickness);
            REG_PERIOD:    prdata = DATA_W'(cfg_reg.pattern_period);
            REG_AMPLITUDE: prdata = DATA_W'(cfg_reg.wave_amplitude);
            REG_PHASE:     prdata = DATA_W'($unsigned(cfg_reg.pattern_phase));
            REG_COLOR:     prdata = cfg_reg.stroke_color;
            REG_SCREEN:    prdata = DATA_W'(cfg_reg.screen_space);
            default:       prdata = '0;
        endcase
    end

    dpsg_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .span_valid (span_valid),
        .span_ready (span_ready),
        .seg_valid  (seg_valid),
        .seg_ready  (seg_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    dpsg_datapath #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .FRAC_BITS    (FRAC_BITS)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .span  (span),
        .cmd   (cmd),
        .sts   (sts),
        .seg   (seg)
    );

`ifndef SYNTH
    a_cfg_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !wr_en |=> (cfg_reg == $past(cfg_reg)))
        else $error("configuration changed without a write");
    a_idle_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && !span_ready) |-> (reg_idx == REG_NONE || cfg_next == cfg_reg))
        else $error("configuration written while a span is in progress");
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (span_valid && span_ready) |-> (cmd.load && !cmd.emit))
        else $error("span accepted outside idle");
`endif

endmodule
`default_nettype wire
